// ===== rtl/sit_pkg.sv =====
// Shared constants and types for the segment intersection test pipeline.
// No dependencies; imported by every module under rtl.
package sit_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int THR_WIDTH       = 33;
  localparam logic [THR_WIDTH-1:0] THR_RESET = THR_WIDTH'(1);
  localparam int NUM_ORIENT      = 4;

  typedef enum logic [1:0] {
    DIR_COLLINEAR = 2'd0,
    DIR_LEFT      = 2'd1,
    DIR_RIGHT     = 2'd2
  } dir_t;

  function automatic logic dir_opposite(input dir_t d0, input dir_t d1);
    return ((d0 == DIR_LEFT) && (d1 == DIR_RIGHT)) ||
           ((d0 == DIR_RIGHT) && (d1 == DIR_LEFT));
  endfunction

endpackage

// ===== rtl/sit_diff.sv =====
// First stage: coordinate differences for the four orientation tests and
// the inclusive bounding box checks. Depends on sit_pkg.
module sit_diff #(
  parameter int COORD_WIDTH = sit_pkg::COORD_WIDTH_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              in_valid,
  output logic                                              in_ready,
  input  logic signed [COORD_WIDTH-1:0]                     a_start_x,
  input  logic signed [COORD_WIDTH-1:0]                     a_start_y,
  input  logic signed [COORD_WIDTH-1:0]                     a_end_x,
  input  logic signed [COORD_WIDTH-1:0]                     a_end_y,
  input  logic signed [COORD_WIDTH-1:0]                     b_start_x,
  input  logic signed [COORD_WIDTH-1:0]                     b_start_y,
  input  logic signed [COORD_WIDTH-1:0]                     b_end_x,
  input  logic signed [COORD_WIDTH-1:0]                     b_end_y,
  input  logic                                              count_touching,
  output logic                                              out_valid,
  input  logic                                              out_ready,
  output logic [sit_pkg::NUM_ORIENT-1:0][COORD_WIDTH:0]     ax,
  output logic [sit_pkg::NUM_ORIENT-1:0][COORD_WIDTH:0]     ay,
  output logic [sit_pkg::NUM_ORIENT-1:0][COORD_WIDTH:0]     bx,
  output logic [sit_pkg::NUM_ORIENT-1:0][COORD_WIDTH:0]     by,
  output logic [sit_pkg::NUM_ORIENT-1:0]                    in_box,
  output logic                                              touch
);
  import sit_pkg::*;

  localparam int DW = COORD_WIDTH + 1;

  logic signed [COORD_WIDTH-1:0] p0x [NUM_ORIENT];
  logic signed [COORD_WIDTH-1:0] p0y [NUM_ORIENT];
  logic signed [COORD_WIDTH-1:0] p1x [NUM_ORIENT];
  logic signed [COORD_WIDTH-1:0] p1y [NUM_ORIENT];
  logic signed [COORD_WIDTH-1:0] qx  [NUM_ORIENT];
  logic signed [COORD_WIDTH-1:0] qy  [NUM_ORIENT];
  logic [NUM_ORIENT-1:0][DW-1:0] ax_next, ay_next, bx_next, by_next;
  logic [NUM_ORIENT-1:0]         in_box_next;

  always_comb begin
    p0x[0] = b_start_x; p0y[0] = b_start_y; p1x[0] = b_end_x; p1y[0] = b_end_y;
    qx[0]  = a_start_x; qy[0]  = a_start_y;
    p0x[1] = b_start_x; p0y[1] = b_start_y; p1x[1] = b_end_x; p1y[1] = b_end_y;
    qx[1]  = a_end_x;   qy[1]  = a_end_y;
    p0x[2] = a_start_x; p0y[2] = a_start_y; p1x[2] = a_end_x; p1y[2] = a_end_y;
    qx[2]  = b_start_x; qy[2]  = b_start_y;
    p0x[3] = a_start_x; p0y[3] = a_start_y; p1x[3] = a_end_x; p1y[3] = a_end_y;
    qx[3]  = b_end_x;   qy[3]  = b_end_y;
  end

  always_comb begin
    for (int k = 0; k < NUM_ORIENT; k++) begin
      ax_next[k] = {p1x[k][COORD_WIDTH-1], p1x[k]} - {p0x[k][COORD_WIDTH-1], p0x[k]};
      ay_next[k] = {p1y[k][COORD_WIDTH-1], p1y[k]} - {p0y[k][COORD_WIDTH-1], p0y[k]};
      bx_next[k] = {qx[k][COORD_WIDTH-1], qx[k]} - {p0x[k][COORD_WIDTH-1], p0x[k]};
      by_next[k] = {qy[k][COORD_WIDTH-1], qy[k]} - {p0y[k][COORD_WIDTH-1], p0y[k]};
      in_box_next[k] = ((qx[k] >= p0x[k]) || (qx[k] >= p1x[k])) &&
                       ((qx[k] <= p0x[k]) || (qx[k] <= p1x[k])) &&
                       ((qy[k] >= p0y[k]) || (qy[k] >= p1y[k])) &&
                       ((qy[k] <= p0y[k]) || (qy[k] <= p1y[k]));
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ax     <= ax_next;
      ay     <= ay_next;
      bx     <= bx_next;
      by     <= by_next;
      in_box <= in_box_next;
      touch  <= count_touching;
    end
  end

endmodule

// ===== rtl/sit_mul.sv =====
// Second stage: the two signed products of each orientation test.
// Depends on sit_pkg.
module sit_mul #(
  parameter int COORD_WIDTH = sit_pkg::COORD_WIDTH_DEF
) (
  input  logic                                                clk,
  input  logic                                                rst,
  input  logic                                                in_valid,
  output logic                                                in_ready,
  input  logic [sit_pkg::NUM_ORIENT-1:0][COORD_WIDTH:0]       ax,
  input  logic [sit_pkg::NUM_ORIENT-1:0][COORD_WIDTH:0]       ay,
  input  logic [sit_pkg::NUM_ORIENT-1:0][COORD_WIDTH:0]       bx,
  input  logic [sit_pkg::NUM_ORIENT-1:0][COORD_WIDTH:0]       by,
  input  logic [sit_pkg::NUM_ORIENT-1:0]                      in_box_in,
  input  logic                                                touch_in,
  output logic                                                out_valid,
  input  logic                                                out_ready,
  output logic [sit_pkg::NUM_ORIENT-1:0][2*COORD_WIDTH+1:0]   prod1,
  output logic [sit_pkg::NUM_ORIENT-1:0][2*COORD_WIDTH+1:0]   prod2,
  output logic [sit_pkg::NUM_ORIENT-1:0]                      in_box,
  output logic                                                touch
);
  import sit_pkg::*;

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;

  logic signed [DW-1:0]          sax, say, sbx, sby;
  logic signed [PW-1:0]          m1, m2;
  logic [NUM_ORIENT-1:0][PW-1:0] prod1_next, prod2_next;

  always_comb begin
    for (int k = 0; k < NUM_ORIENT; k++) begin
      sax = $signed(ax[k]);
      say = $signed(ay[k]);
      sbx = $signed(bx[k]);
      sby = $signed(by[k]);
      m1  = sax * sby;
      m2  = sbx * say;
      prod1_next[k] = m1;
      prod2_next[k] = m2;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      prod1  <= prod1_next;
      prod2  <= prod2_next;
      in_box <= in_box_in;
      touch  <= touch_in;
    end
  end

endmodule

// ===== rtl/sit_cross.sv =====
// Third stage: exact cross products as the difference of the two products.
// Depends on sit_pkg.
module sit_cross #(
  parameter int COORD_WIDTH = sit_pkg::COORD_WIDTH_DEF
) (
  input  logic                                                clk,
  input  logic                                                rst,
  input  logic                                                in_valid,
  output logic                                                in_ready,
  input  logic [sit_pkg::NUM_ORIENT-1:0][2*COORD_WIDTH+1:0]   prod1,
  input  logic [sit_pkg::NUM_ORIENT-1:0][2*COORD_WIDTH+1:0]   prod2,
  input  logic [sit_pkg::NUM_ORIENT-1:0]                      in_box_in,
  input  logic                                                touch_in,
  output logic                                                out_valid,
  input  logic                                                out_ready,
  output logic [sit_pkg::NUM_ORIENT-1:0][2*COORD_WIDTH+2:0]   cross_prod,
  output logic [sit_pkg::NUM_ORIENT-1:0]                      in_box,
  output logic                                                touch
);
  import sit_pkg::*;

  localparam int PW = 2 * COORD_WIDTH + 2;
  localparam int XW = PW + 1;

  logic [NUM_ORIENT-1:0][XW-1:0] cross_next;

  always_comb begin
    for (int k = 0; k < NUM_ORIENT; k++) begin
      cross_next[k] = {prod1[k][PW-1], prod1[k]} - {prod2[k][PW-1], prod2[k]};
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cross_prod <= cross_next;
      in_box     <= in_box_in;
      touch      <= touch_in;
    end
  end

endmodule

// ===== rtl/sit_class.sv =====
// Last stage: classify each cross product against the threshold and form
// the registered intersection result. Depends on sit_pkg.
module sit_class #(
  parameter int COORD_WIDTH = sit_pkg::COORD_WIDTH_DEF
) (
  input  logic                                                clk,
  input  logic                                                rst,
  input  logic                                                in_valid,
  output logic                                                in_ready,
  input  logic [sit_pkg::NUM_ORIENT-1:0][2*COORD_WIDTH+2:0]   cross_prod,
  input  logic [sit_pkg::NUM_ORIENT-1:0]                      in_box,
  input  logic                                                touch,
  input  logic [sit_pkg::THR_WIDTH-1:0]                       threshold,
  output logic                                                out_valid,
  input  logic                                                out_ready,
  output logic                                                intersects
);
  import sit_pkg::*;

  localparam int XW = 2 * COORD_WIDTH + 3;
  localparam int CW = (XW > THR_WIDTH + 1) ? XW : THR_WIDTH + 1;

  logic signed [XW-1:0] sx;
  logic signed [CW-1:0] cx;
  logic signed [CW-1:0] thr_pos, thr_neg;
  dir_t                 dir [NUM_ORIENT];
  logic                 crossing, touching, intersects_next;

  assign thr_pos = $signed(CW'(threshold));
  assign thr_neg = -thr_pos;

  always_comb begin
    for (int k = 0; k < NUM_ORIENT; k++) begin
      sx = $signed(cross_prod[k]);
      cx = CW'(sx);
      if ((cx < thr_pos) && (cx > thr_neg)) begin
        dir[k] = DIR_COLLINEAR;
      end else if (cx < 0) begin
        dir[k] = DIR_RIGHT;
      end else begin
        dir[k] = DIR_LEFT;
      end
    end
  end

  always_comb begin
    crossing = dir_opposite(dir[0], dir[1]) && dir_opposite(dir[2], dir[3]);
    touching = 1'b0;
    for (int k = 0; k < NUM_ORIENT; k++) begin
      touching = touching || ((dir[k] == DIR_COLLINEAR) && in_box[k]);
    end
    intersects_next = crossing || (touch && touching);
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      intersects <= intersects_next;
    end
  end

endmodule

// ===== rtl/segment_intersection_test_top.sv =====
// Segment intersection test: top level with the threshold register and
// the four pipeline stages. Depends on sit_pkg, sit_diff, sit_mul,
// sit_cross and sit_class.
//
// Usage: present two segments and count_touching on the input channel
// (in_valid / in_ready); one intersects bit per item comes back on the
// output channel (out_valid / out_ready) in the same order.
// Stages: differences and box checks, products, cross products and
// classification, each ending in its own output register.
// Throughput: one item per cycle unless stalled; each stage holds its
// own valid bit, so an empty stage fills even while the output is stalled.
// Stall: with out_ready low the result register holds, stages behind it
// fill up and in_ready drops once every stage is occupied.
// Reset: rst (synchronous, active high) empties the pipeline and sets
// collinear_threshold to 1.
// Configuration: cfg_wr_en loads cfg_wr_data into the collinear_threshold
// register; write it only while the pipeline is empty.
module segment_intersection_test_top #(
  parameter int COORD_WIDTH = sit_pkg::COORD_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [sit_pkg::THR_WIDTH-1:0]    cfg_wr_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [COORD_WIDTH-1:0]    a_start_x,
  input  logic signed [COORD_WIDTH-1:0]    a_start_y,
  input  logic signed [COORD_WIDTH-1:0]    a_end_x,
  input  logic signed [COORD_WIDTH-1:0]    a_end_y,
  input  logic signed [COORD_WIDTH-1:0]    b_start_x,
  input  logic signed [COORD_WIDTH-1:0]    b_start_y,
  input  logic signed [COORD_WIDTH-1:0]    b_end_x,
  input  logic signed [COORD_WIDTH-1:0]    b_end_y,
  input  logic                             count_touching,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             intersects
);
  import sit_pkg::*;

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;
  localparam int XW = PW + 1;

  logic [THR_WIDTH-1:0] collinear_threshold;

  logic                          s1_valid, s1_ready;
  logic [NUM_ORIENT-1:0][DW-1:0] s1_ax, s1_ay, s1_bx, s1_by;
  logic [NUM_ORIENT-1:0]         s1_box;
  logic                          s1_touch;

  logic                          s2_valid, s2_ready;
  logic [NUM_ORIENT-1:0][PW-1:0] s2_prod1, s2_prod2;
  logic [NUM_ORIENT-1:0]         s2_box;
  logic                          s2_touch;

  logic                          s3_valid, s3_ready;
  logic [NUM_ORIENT-1:0][XW-1:0] s3_cross;
  logic [NUM_ORIENT-1:0]         s3_box;
  logic                          s3_touch;

  always_ff @(posedge clk) begin
    if (rst) begin
      collinear_threshold <= THR_RESET;
    end else if (cfg_wr_en) begin
      collinear_threshold <= cfg_wr_data;
    end
  end

  sit_diff #(.COORD_WIDTH(COORD_WIDTH)) u_diff (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .a_start_x      (a_start_x),
    .a_start_y      (a_start_y),
    .a_end_x        (a_end_x),
    .a_end_y        (a_end_y),
    .b_start_x      (b_start_x),
    .b_start_y      (b_start_y),
    .b_end_x        (b_end_x),
    .b_end_y        (b_end_y),
    .count_touching (count_touching),
    .out_valid      (s1_valid),
    .out_ready      (s1_ready),
    .ax             (s1_ax),
    .ay             (s1_ay),
    .bx             (s1_bx),
    .by             (s1_by),
    .in_box         (s1_box),
    .touch          (s1_touch)
  );

  sit_mul #(.COORD_WIDTH(COORD_WIDTH)) u_mul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .ax        (s1_ax),
    .ay        (s1_ay),
    .bx        (s1_bx),
    .by        (s1_by),
    .in_box_in (s1_box),
    .touch_in  (s1_touch),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .prod1     (s2_prod1),
    .prod2     (s2_prod2),
    .in_box    (s2_box),
    .touch     (s2_touch)
  );

  sit_cross #(.COORD_WIDTH(COORD_WIDTH)) u_cross (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s2_valid),
    .in_ready   (s2_ready),
    .prod1      (s2_prod1),
    .prod2      (s2_prod2),
    .in_box_in  (s2_box),
    .touch_in   (s2_touch),
    .out_valid  (s3_valid),
    .out_ready  (s3_ready),
    .cross_prod (s3_cross),
    .in_box     (s3_box),
    .touch      (s3_touch)
  );

  sit_class #(.COORD_WIDTH(COORD_WIDTH)) u_class (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s3_valid),
    .in_ready   (s3_ready),
    .cross_prod (s3_cross),
    .in_box     (s3_box),
    .touch      (s3_touch),
    .threshold  (collinear_threshold),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .intersects (intersects)
  );

endmodule
